// ===== design/sfcd_pkg.sv =====
`default_nettype none

package sfcd_pkg;

  // Framing bytes
  localparam logic [7:0] START_BYTE  = 8'h7E;
  localparam logic [7:0] ESCAPE_BYTE = 8'h7D;
  localparam logic [7:0] ESCAPE_FLIP = 8'h20;

  // Frame check
  localparam logic [15:0] CHECK_POLY = 16'h1021;
  localparam logic [15:0] CHECK_INIT = 16'hFFFF;

  // Command ids and minimum payload lengths
  localparam logic [7:0] ID_RUN      = 8'd1;
  localparam logic [7:0] ID_TURN     = 8'd2;
  localparam logic [7:0] LEN_RUN     = 8'd4;
  localparam logic [7:0] LEN_TURN    = 8'd5;

  // Number of payload bytes that a command decode looks at
  localparam int unsigned CMD_BYTES = 5;

  // Defaults
  localparam int unsigned MAX_PAYLOAD_DEF = 8;
  localparam logic [6:0]  LIMIT_RESET     = 7'd100;

  // Command kinds
  localparam logic KIND_RUN  = 1'b0;
  localparam logic KIND_TURN = 1'b1;

  typedef enum logic [2:0] {
    PH_WAIT    = 3'd0,
    PH_ID      = 3'd1,
    PH_LEN     = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CHK_HI  = 3'd4,
    PH_CHK_LO  = 3'd5
  } phase_e;

  // Finished frame handed from the deframer to the output stage
  typedef struct packed {
    logic                           hit;
    logic                           kind;
    logic [CMD_BYTES-1:0][7:0]      pl;
  } frame_t;

  // Byte-wide CRC-16-CCITT update, MSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (r[15]) begin
        r = {r[14:0], 1'b0} ^ CHECK_POLY;
      end else begin
        r = {r[14:0], 1'b0};
      end
    end
    return r;
  endfunction

  // Clamp a signed speed byte to -lim .. +lim
  function automatic logic [7:0] sat_speed(input logic [7:0] b, input logic [6:0] lim);
    logic signed [8:0] v;
    logic signed [8:0] hi;
    logic signed [8:0] lo;
    logic signed [8:0] r;
    v  = $signed({b[7], b});
    hi = $signed({2'b00, lim});
    lo = -hi;
    r  = v;
    if (v < lo) begin
      r = lo;
    end
    if (v > hi) begin
      r = hi;
    end
    return r[7:0];
  endfunction

endpackage

`default_nettype wire

// ===== design/stuffed_frame_command_decoder_top.sv =====
`default_nettype none

// Byte-stuffed frame command decoder. Takes one raw line byte per transfer on
// rx and parses 0x7E-delimited frames (id, length, payload, CRC-16-CCITT);
// a run or turn frame with a good check gives one command transfer on cmd,
// speeds clamped to +/- speed_limit (APB register at address 0, reset 100).
// A byte is taken every cycle while rx_ready_o is high: the parser and the
// byte-wide CRC update act on the accepted byte, and the command lands in an
// output register in the cycle after the last check byte is taken. rx_ready_o
// drops only while a command sits in that register and cmd_ready_i is low.
module stuffed_frame_command_decoder_top #(
  parameter int unsigned MAX_PAYLOAD = sfcd_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // received bytes
  input  wire logic        rx_valid_i,
  output logic             rx_ready_o,
  input  wire logic [7:0]  rx_byte_i,
  // decoded commands
  output logic             cmd_valid_o,
  input  wire logic        cmd_ready_i,
  output logic             command_kind_o,
  output logic             enable_flag_o,
  output logic signed [7:0] speed_first_o,
  output logic signed [7:0] speed_second_o,
  output logic signed [7:0] speed_third_o,
  output logic [7:0]       turn_amount_o,
  output logic             turn_direction_o,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import sfcd_pkg::*;

  logic       take;
  frame_t     frame;
  logic [6:0] limit_q;
  logic       valid_q, valid_d;
  logic       kind_q, en_q, dir_q;
  logic [7:0] s1_q, s2_q, s3_q, amt_q;
  logic       load;

  // Configuration register, a single word at offset 0
  assign pready = 1'b1;
  assign prdata = {25'd0, limit_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && paddr == 2'd0) begin
      limit_q <= pwdata[6:0];
    end
  end

  // Take a byte unless a command is held and not being drained
  assign rx_ready_o = !valid_q || cmd_ready_i;
  assign take       = rx_valid_i && rx_ready_o;

  sfcd_deframer #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_deframer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .take_i  (take),
    .byte_i  (rx_byte_i),
    .frame_o (frame)
  );

  assign load = frame.hit;

  // Output valid: set on a decoded frame, clear on transfer
  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (cmd_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Decode and clamp into the output register
  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= frame.kind;
      s1_q   <= sat_speed(frame.pl[0], limit_q);
      if (frame.kind == KIND_TURN) begin
        en_q  <= (frame.pl[4] != 8'd0);
        s2_q  <= 8'd0;
        s3_q  <= sat_speed(frame.pl[3], limit_q);
        amt_q <= frame.pl[1];
        dir_q <= (frame.pl[2] != 8'd0);
      end else begin
        en_q  <= (frame.pl[3] != 8'd0);
        s2_q  <= sat_speed(frame.pl[1], limit_q);
        s3_q  <= sat_speed(frame.pl[2], limit_q);
        amt_q <= 8'd0;
        dir_q <= 1'b0;
      end
    end
  end

  assign cmd_valid_o      = valid_q;
  assign command_kind_o   = kind_q;
  assign enable_flag_o    = en_q;
  assign speed_first_o    = $signed(s1_q);
  assign speed_second_o   = $signed(s2_q);
  assign speed_third_o    = $signed(s3_q);
  assign turn_amount_o    = amt_q;
  assign turn_direction_o = dir_q;

endmodule

`default_nettype wire

// ===== design/sfcd_deframer.sv =====
`default_nettype none

module sfcd_deframer #(
  parameter int unsigned MAX_PAYLOAD = sfcd_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          take_i,
  input  wire logic [7:0]    byte_i,
  output sfcd_pkg::frame_t   frame_o
);
  import sfcd_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_PAYLOAD + 1);

  phase_e            phase_q, phase_d;
  logic              esc_q, esc_d;
  logic [7:0]        id_q, id_d;
  logic [7:0]        len_q, len_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [15:0]       crc_q, crc_d;
  logic [7:0]        chk_hi_q, chk_hi_d;
  logic [CMD_BYTES-1:0][7:0] store_q;
  logic [CMD_BYTES-1:0]      store_we;

  logic [7:0]        data;
  logic [15:0]       crc_next;
  logic [IdxW-1:0]   idx_inc;
  logic              check_ok;

  assign data     = esc_q ? (byte_i ^ ESCAPE_FLIP) : byte_i;
  assign crc_next = crc_byte(crc_q, data);
  assign idx_inc  = idx_q + 1'b1;
  assign check_ok = ({chk_hi_q, data} == crc_q);

  // Next state of the parser and the finished-frame strobe
  always_comb begin
    phase_d      = phase_q;
    esc_d        = esc_q;
    id_d         = id_q;
    len_d        = len_q;
    idx_d        = idx_q;
    crc_d        = crc_q;
    chk_hi_d     = chk_hi_q;
    store_we     = '0;
    frame_o.hit  = 1'b0;
    frame_o.kind = (id_q == ID_TURN) ? KIND_TURN : KIND_RUN;
    frame_o.pl   = store_q;

    if (take_i) begin
      if (byte_i == START_BYTE) begin
        // resync on a raw start byte
        phase_d = PH_ID;
        esc_d   = 1'b0;
        crc_d   = CHECK_INIT;
      end else if (phase_q == PH_WAIT) begin
        phase_d = PH_WAIT;
      end else if (!esc_q && byte_i == ESCAPE_BYTE) begin
        esc_d = 1'b1;
      end else begin
        esc_d = 1'b0;
        case (phase_q)
          PH_ID: begin
            id_d    = data;
            crc_d   = crc_next;
            phase_d = PH_LEN;
          end
          PH_LEN: begin
            len_d = data;
            crc_d = crc_next;
            idx_d = '0;
            if (data > 8'(MAX_PAYLOAD)) begin
              phase_d = PH_WAIT;
            end else if (data != 8'd0) begin
              phase_d = PH_PAYLOAD;
            end else begin
              phase_d = PH_CHK_HI;
            end
          end
          PH_PAYLOAD: begin
            for (int i = 0; i < CMD_BYTES; i++) begin
              store_we[i] = (idx_q == IdxW'(i));
            end
            idx_d = idx_inc;
            crc_d = crc_next;
            if (8'(idx_inc) >= len_q) begin
              phase_d = PH_CHK_HI;
            end
          end
          PH_CHK_HI: begin
            chk_hi_d = data;
            phase_d  = PH_CHK_LO;
          end
          PH_CHK_LO: begin
            phase_d     = PH_WAIT;
            frame_o.hit = check_ok &&
                          ((id_q == ID_RUN  && len_q >= LEN_RUN) ||
                           (id_q == ID_TURN && len_q >= LEN_TURN));
          end
          default: begin
            phase_d = PH_WAIT;
          end
        endcase
      end
    end
  end

  // Parser control and check state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_WAIT;
      esc_q    <= 1'b0;
      id_q     <= '0;
      len_q    <= '0;
      idx_q    <= '0;
      crc_q    <= CHECK_INIT;
      chk_hi_q <= '0;
    end else begin
      phase_q  <= phase_d;
      esc_q    <= esc_d;
      id_q     <= id_d;
      len_q    <= len_d;
      idx_q    <= idx_d;
      crc_q    <= crc_d;
      chk_hi_q <= chk_hi_d;
    end
  end

  // Keep the payload bytes that a command decode reads
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < CMD_BYTES; i++) begin
      if (store_we[i]) begin
        store_q[i] <= data;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/sfcd_checker.sv =====
`default_nettype none

module sfcd_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        rx_ready_o,
  input wire logic        cmd_valid_o,
  input wire logic        cmd_ready_i,
  input wire logic        command_kind_o,
  input wire logic [7:0]  speed_first_o,
  input wire logic [7:0]  speed_second_o,
  input wire logic [7:0]  speed_third_o,
  input wire logic [7:0]  turn_amount_o,
  input wire logic        turn_direction_o
);

  // Input stalls only behind a held command
  a_stall_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rx_ready_o |-> (cmd_valid_o && !cmd_ready_i))
    else $error("rx stalled without a held command");

  // A clamped speed never reaches -128
  a_speed_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_o |-> (speed_first_o != 8'h80 && speed_second_o != 8'h80 &&
                     speed_third_o != 8'h80))
    else $error("speed outside the clamp range");

  // Fields unused by a command kind are zero
  a_kind_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_o |-> (command_kind_o ? (speed_second_o == 8'd0)
                                    : (turn_amount_o == 8'd0 && !turn_direction_o)))
    else $error("unused command fields not zero");

  // Held command stays valid and keeps its first speed and its kind
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid_o && !cmd_ready_i) |=> (cmd_valid_o && $stable(speed_first_o) &&
                                       $stable(command_kind_o)))
    else $error("held command changed");

endmodule

bind stuffed_frame_command_decoder_top sfcd_checker u_sfcd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .rx_ready_o       (rx_ready_o),
  .cmd_valid_o      (cmd_valid_o),
  .cmd_ready_i      (cmd_ready_i),
  .command_kind_o   (command_kind_o),
  .speed_first_o    (speed_first_o),
  .speed_second_o   (speed_second_o),
  .speed_third_o    (speed_third_o),
  .turn_amount_o    (turn_amount_o),
  .turn_direction_o (turn_direction_o)
);

`default_nettype wire

// ===== sim/tb_stuffed_frame_command_decoder_top.sv =====
`default_nettype none

module tb_stuffed_frame_command_decoder_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sfcd_pkg::*;

  localparam int unsigned PAYLOAD_DEPTH = MAX_PAYLOAD_DEF;
  // Byte address of the speed limit register (register 0)
  localparam logic [1:0]  SPEED_LIMIT_ADDR = 2'd0;
  localparam int          IDLE_SETTLE = 6;
  localparam int          END_SETTLE = 20;
  localparam int          HOLD_OFF_CYCLES = 200;
  localparam int          SEGMENT_BYTES = 230;

  typedef enum int {
    FRM_GOOD,
    FRM_BAD_CHECK,
    FRM_TRUNC
  } frame_mode_e;

  typedef struct packed {
    logic       kind;
    logic       enable;
    logic [7:0] speed_first;
    logic [7:0] speed_second;
    logic [7:0] speed_third;
    logic [7:0] amount;
    logic       direction;
  } command_t;

  logic        clk = 1'b0;
  logic        rst_ni = 1'b0;
  logic        rx_valid = 1'b0;
  logic [7:0]  rx_byte = 8'h00;
  logic        cmd_ready = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = 2'd0;
  logic [31:0] pwdata = 32'd0;

  wire logic        rx_ready_o;
  wire logic        cmd_valid_o;
  wire logic        command_kind_o;
  wire logic        enable_flag_o;
  wire logic [7:0]  speed_first_o;
  wire logic [7:0]  speed_second_o;
  wire logic [7:0]  speed_third_o;
  wire logic [7:0]  turn_amount_o;
  wire logic        turn_direction_o;
  wire logic [31:0] prdata;
  wire logic        pready;

  // Decoder mirror state
  phase_e      parse_ph = PH_WAIT;
  bit          esc_pend = 1'b0;
  logic [7:0]  frm_id = 8'h00;
  logic [7:0]  frm_len = 8'h00;
  logic [7:0]  pl_seen [0:PAYLOAD_DEPTH-1];
  int          pl_idx = 0;
  logic [15:0] run_crc = CHECK_INIT;
  logic [7:0]  chk_hi_seen = 8'h00;
  logic [6:0]  cur_limit = LIMIT_RESET;

  command_t    pending_cmds [$];
  command_t    observed_cmd;
  command_t    wanted_cmd;
  int          err_count = 0;
  int          bytes_sent = 0;
  int          hold_left = 0;
  bit          sender_idle_en = 1'b1;
  bit          recv_idle_en = 1'b1;
  bit          extra_esc_en = 1'b0;
  logic [7:0]  pl_buf [0:15];

  stuffed_frame_command_decoder_top dut (
    .clk_i            (clk),
    .rst_ni           (rst_ni),
    .rx_valid_i       (rx_valid),
    .rx_ready_o       (rx_ready_o),
    .rx_byte_i        (rx_byte),
    .cmd_valid_o      (cmd_valid_o),
    .cmd_ready_i      (cmd_ready),
    .command_kind_o   (command_kind_o),
    .enable_flag_o    (enable_flag_o),
    .speed_first_o    (speed_first_o),
    .speed_second_o   (speed_second_o),
    .speed_third_o    (speed_third_o),
    .turn_amount_o    (turn_amount_o),
    .turn_direction_o (turn_direction_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // CRC-16-CCITT, MSB first, one byte
  function automatic logic [15:0] line_crc(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    repeat (8) r = r[15] ? ((r << 1) ^ CHECK_POLY) : (r << 1);
    return r;
  endfunction

  // Saturate a signed speed byte to +/- the current limit
  function automatic logic [7:0] clamp_speed_byte(input logic [7:0] b);
    int v;
    int lim;
    v = $signed(b);
    lim = cur_limit;
    if (v < -lim) v = -lim;
    if (v > lim) v = lim;
    return v[7:0];
  endfunction

  // Payload byte biased toward the clamp corners and the framing bytes
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0: return 8'h80;
      1: return 8'h7F;
      2: return 8'h00;
      3: return $urandom_range(1) ? START_BYTE : ESCAPE_BYTE;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Advance the decoder mirror by one accepted line byte
  task automatic decode_line_byte(input logic [7:0] raw);
    logic [7:0] d;
    command_t   c;
    if (raw == START_BYTE) begin
      parse_ph = PH_ID;
      esc_pend = 1'b0;
      run_crc = CHECK_INIT;
      return;
    end
    if (parse_ph == PH_WAIT) return;
    if (esc_pend) begin
      d = raw ^ ESCAPE_FLIP;
      esc_pend = 1'b0;
    end else if (raw == ESCAPE_BYTE) begin
      esc_pend = 1'b1;
      return;
    end else begin
      d = raw;
    end
    case (parse_ph)
      PH_ID: begin
        frm_id = d;
        run_crc = line_crc(run_crc, d);
        parse_ph = PH_LEN;
      end
      PH_LEN: begin
        frm_len = d;
        run_crc = line_crc(run_crc, d);
        pl_idx = 0;
        if (d > PAYLOAD_DEPTH) parse_ph = PH_WAIT;
        else if (d == 8'd0) parse_ph = PH_CHK_HI;
        else parse_ph = PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        if (pl_idx < PAYLOAD_DEPTH) pl_seen[pl_idx] = d;
        pl_idx++;
        run_crc = line_crc(run_crc, d);
        if (pl_idx >= frm_len) parse_ph = PH_CHK_HI;
      end
      PH_CHK_HI: begin
        chk_hi_seen = d;
        parse_ph = PH_CHK_LO;
      end
      default: begin
        parse_ph = PH_WAIT;
        if ({chk_hi_seen, d} == run_crc) begin
          if (frm_id == ID_RUN && frm_len >= LEN_RUN) begin
            c.kind = KIND_RUN;
            c.enable = (pl_seen[3] != 8'h00);
            c.speed_first = clamp_speed_byte(pl_seen[0]);
            c.speed_second = clamp_speed_byte(pl_seen[1]);
            c.speed_third = clamp_speed_byte(pl_seen[2]);
            c.amount = 8'h00;
            c.direction = 1'b0;
            pending_cmds.push_back(c);
          end else if (frm_id == ID_TURN && frm_len >= LEN_TURN) begin
            c.kind = KIND_TURN;
            c.enable = (pl_seen[4] != 8'h00);
            c.speed_first = clamp_speed_byte(pl_seen[0]);
            c.speed_second = 8'h00;
            c.speed_third = clamp_speed_byte(pl_seen[3]);
            c.amount = pl_seen[1];
            c.direction = (pl_seen[2] != 8'h00);
            pending_cmds.push_back(c);
          end
        end
      end
    endcase
  endtask

  // Track every rx transfer
  always @(posedge clk) begin
    if (rst_ni && rx_valid && rx_ready_o) decode_line_byte(rx_byte);
  end

  // Compare every cmd transfer against the oldest predicted command
  always @(posedge clk) begin
    if (rst_ni && cmd_valid_o && cmd_ready) begin
      observed_cmd = {command_kind_o, enable_flag_o, speed_first_o, speed_second_o,
                      speed_third_o, turn_amount_o, turn_direction_o};
      if (pending_cmds.size() == 0) begin
        $display("%0t: command with none predicted: kind=%0d s1=%0d", $time,
                 observed_cmd.kind, $signed(observed_cmd.speed_first));
        err_count++;
      end else begin
        wanted_cmd = pending_cmds.pop_front();
        if (observed_cmd !== wanted_cmd) begin
          $display("%0t: expected kind=%0d en=%0d s1=%0d s2=%0d s3=%0d amt=%0d dir=%0d",
                   $time, wanted_cmd.kind, wanted_cmd.enable,
                   $signed(wanted_cmd.speed_first), $signed(wanted_cmd.speed_second),
                   $signed(wanted_cmd.speed_third), wanted_cmd.amount,
                   wanted_cmd.direction);
          $display("%0t: actual   kind=%0d en=%0d s1=%0d s2=%0d s3=%0d amt=%0d dir=%0d",
                   $time, observed_cmd.kind, observed_cmd.enable,
                   $signed(observed_cmd.speed_first), $signed(observed_cmd.speed_second),
                   $signed(observed_cmd.speed_third), observed_cmd.amount,
                   observed_cmd.direction);
          err_count++;
        end
      end
    end
  end

  // Command receiver: long hold-off when requested, else random stalls while idling is enabled
  always @(posedge clk) begin
    if (hold_left > 0) begin
      cmd_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (recv_idle_en) begin
      cmd_ready <= ($urandom_range(99) >= 30);
    end else begin
      cmd_ready <= 1'b1;
    end
  end

  // Offer one raw byte, hold it until the transfer
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    if (sender_idle_en && $urandom_range(99) < 30) gap = $urandom_range(2, 1);
    if (gap > 0) begin
      rx_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (!rx_ready_o) @(posedge clk);
    bytes_sent++;
  endtask

  // Send one frame byte, escaping framing bytes and optionally others
  task automatic send_data(input logic [7:0] b);
    logic [7:0] flipped;
    flipped = b ^ ESCAPE_FLIP;
    if (b == START_BYTE || b == ESCAPE_BYTE ||
        (extra_esc_en && flipped != START_BYTE && flipped != ESCAPE_BYTE &&
         $urandom_range(99) < 5)) begin
      send_byte(ESCAPE_BYTE);
      send_byte(flipped);
    end else begin
      send_byte(b);
    end
  endtask

  // Start byte, id, length, n payload bytes from pl_buf, then the check unless truncated
  task automatic drive_frame(input logic [7:0] id, input logic [7:0] len, input int n,
                             input frame_mode_e mode);
    logic [15:0] crc;
    crc = CHECK_INIT;
    send_byte(START_BYTE);
    send_data(id);
    crc = line_crc(crc, id);
    send_data(len);
    crc = line_crc(crc, len);
    for (int i = 0; i < n; i++) begin
      send_data(pl_buf[i]);
      crc = line_crc(crc, pl_buf[i]);
    end
    if (mode != FRM_TRUNC) begin
      if (mode == FRM_BAD_CHECK) crc = crc ^ (16'd1 << $urandom_range(15));
      send_data(crc[15:8]);
      send_data(crc[7:0]);
    end
  endtask

  task automatic load_payload(input logic [63:0] bytes);
    for (int i = 0; i < 8; i++) pl_buf[i] = bytes[63-8*i -: 8];
  endtask

  task automatic fill_payload(input int n);
    for (int i = 0; i < n; i++) pl_buf[i] = pick_byte();
  endtask

  // Drop valid and wait until every predicted command has come out
  task automatic wait_idle();
    rx_valid <= 1'b0;
    @(posedge clk);
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  // APB write then read back of the speed limit
  task automatic set_speed_limit(input logic [6:0] lim);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= SPEED_LIMIT_ADDR;
    pwdata <= {25'd0, lim};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    cur_limit = lim;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    psel <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[6:0] !== cur_limit) begin
      $display("%0t: speed limit readback expected %0d actual %0d", $time, cur_limit,
               prdata[6:0]);
      err_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_run_commands();
    load_payload(64'h80_7F_00_01_00_00_00_00);
    drive_frame(ID_RUN, 8'd4, 4, FRM_GOOD);
    load_payload(64'h81_64_9C_00_7E_7D_FF_01);
    drive_frame(ID_RUN, 8'd8, 8, FRM_GOOD);
  endtask

  task automatic test_turn_commands();
    load_payload(64'h7F_FF_01_80_05_00_00_00);
    drive_frame(ID_TURN, 8'd5, 5, FRM_GOOD);
    load_payload(64'h9B_00_00_65_00_7D_7E_11);
    drive_frame(ID_TURN, 8'd8, 8, FRM_GOOD);
  endtask

  task automatic test_frame_errors();
    // bytes outside a frame
    send_byte(8'h11);
    send_byte(ESCAPE_BYTE);
    send_byte(8'hA5);
    // oversized length, then a good frame right after
    load_payload(64'h01_02_03_04_05_06_07_08);
    drive_frame(ID_RUN, 8'd9, 3, FRM_GOOD);
    drive_frame(ID_RUN, 8'd4, 4, FRM_GOOD);
    // zero length, short run, short turn, unknown id
    drive_frame(ID_RUN, 8'd0, 0, FRM_GOOD);
    drive_frame(ID_RUN, 8'd3, 3, FRM_GOOD);
    drive_frame(ID_TURN, 8'd4, 4, FRM_GOOD);
    drive_frame(8'd3, 8'd5, 5, FRM_GOOD);
    // bad check
    drive_frame(ID_RUN, 8'd4, 4, FRM_BAD_CHECK);
    // restart mid-frame
    drive_frame(ID_TURN, 8'd6, 3, FRM_TRUNC);
    drive_frame(ID_TURN, 8'd6, 6, FRM_GOOD);
    // escape just before a start byte
    send_byte(START_BYTE);
    send_byte(8'h01);
    send_byte(ESCAPE_BYTE);
    drive_frame(ID_RUN, 8'd5, 5, FRM_GOOD);
  endtask

  task automatic test_speed_limits();
    logic [6:0] limits [4];
    limits = '{7'd0, 7'd127, 7'd1, LIMIT_RESET};
    foreach (limits[i]) begin
      wait_idle();
      set_speed_limit(limits[i]);
      load_payload(64'h80_7F_81_01_02_00_00_00);
      drive_frame(ID_RUN, 8'd4, 4, FRM_GOOD);
      load_payload(64'h01_80_00_FF_00_00_00_00);
      drive_frame(ID_TURN, 8'd5, 5, FRM_GOOD);
    end
  endtask

  task automatic test_backpressure();
    wait_idle();
    sender_idle_en = 1'b0;
    hold_left = HOLD_OFF_CYCLES;
    repeat (6) begin
      fill_payload(4);
      drive_frame(ID_RUN, 8'd4, 4, FRM_GOOD);
    end
    sender_idle_en = 1'b1;
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int target;
    int pick;
    int n;
    logic [7:0] id;
    extra_esc_en = 1'b1;
    for (int seg = 0; seg < 4; seg++) begin
      wait_idle();
      set_speed_limit(seg == 1 ? 7'd127 : 7'($urandom_range(127)));
      // one segment runs with no idling on either side
      sender_idle_en = (seg != 2);
      recv_idle_en = (seg != 2);
      target = bytes_sent + SEGMENT_BYTES;
      while (bytes_sent < target) begin
        pick = $urandom_range(99);
        if (pick < 65) begin
          id = $urandom_range(1) ? ID_TURN : ID_RUN;
          n = (id == ID_RUN) ? $urandom_range(8, 4) : $urandom_range(8, 5);
          fill_payload(n);
          drive_frame(id, 8'(n), n, FRM_GOOD);
        end else if (pick < 75) begin
          n = $urandom_range(8);
          fill_payload(n);
          drive_frame(8'($urandom_range(255)), 8'(n), n, FRM_GOOD);
        end else if (pick < 85) begin
          id = $urandom_range(1) ? ID_TURN : ID_RUN;
          n = $urandom_range(8, 4);
          fill_payload(n);
          drive_frame(id, 8'(n), $urandom_range(1) ? n : $urandom_range(n),
                      $urandom_range(1) ? FRM_BAD_CHECK : FRM_TRUNC);
        end else if (pick < 92) begin
          n = $urandom_range(10);
          fill_payload(n);
          drive_frame($urandom_range(1) ? ID_TURN : ID_RUN, 8'($urandom_range(255, 9)), n,
                      FRM_GOOD);
        end else begin
          repeat ($urandom_range(6, 1)) send_byte(8'($urandom_range(255)));
        end
      end
    end
    sender_idle_en = 1'b1;
    recv_idle_en = 1'b1;
    extra_esc_en = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);
    test_run_commands();
    test_turn_commands();
    test_frame_errors();
    test_speed_limits();
    test_backpressure();
    test_random_traffic();
    wait_idle();
    repeat (END_SETTLE) @(posedge clk);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

`default_nettype wire

// ===== stuffed_frame_command_decoder_top.f =====
design/sfcd_pkg.sv
design/sfcd_deframer.sv
design/stuffed_frame_command_decoder_top.sv
design/sfcd_checker.sv
sim/tb_stuffed_frame_command_decoder_top.sv
